// ===== hdl/wpe_pkg.sv =====
// Package for the wake packet port extractor: ethertype and protocol codes,
// class codes, the flow and result structs and the header helper functions.
// No dependencies.
`default_nettype none

package wpe_pkg;

    localparam logic [15:0] ETH_IPV4  = 16'h0800;
    localparam logic [15:0] ETH_IPV6  = 16'h86DD;
    localparam logic [15:0] ETH_ARP   = 16'h0806;
    localparam logic [15:0] ETH_EAPOL = 16'h888E;
    localparam logic [15:0] VENDOR_ETH_RESET = 16'h886C;

    localparam logic [7:0] PROTO_HOPOPT = 8'd0;
    localparam logic [7:0] PROTO_ICMP   = 8'd1;
    localparam logic [7:0] PROTO_IGMP   = 8'd2;
    localparam logic [7:0] PROTO_TCP    = 8'd6;
    localparam logic [7:0] PROTO_UDP    = 8'd17;
    localparam logic [7:0] PROTO_ROUTE  = 8'd43;
    localparam logic [7:0] PROTO_FRAG   = 8'd44;
    localparam logic [7:0] PROTO_AUTH   = 8'd51;
    localparam logic [7:0] PROTO_DSTOPT = 8'd60;

    localparam int V6_HDR_BYTES = 40;
    localparam int OPT_UNIT     = 8;
    localparam int AUTH_UNIT    = 4;
    localparam int PORT_BYTES   = 4;

    // register index on the APB port
    localparam logic [1:0] REG_VENDOR_ETH = 2'd0;

    typedef enum logic [3:0] {
        CLS_V4UDP   = 4'd0,
        CLS_V4TCP   = 4'd1,
        CLS_V4ICMP  = 4'd2,
        CLS_V4IGMP  = 4'd3,
        CLS_V4OTHER = 4'd4,
        CLS_V6TCP   = 4'd5,
        CLS_V6UDP   = 4'd6,
        CLS_V6OTHER = 4'd7,
        CLS_ARP     = 4'd8,
        CLS_VENDOR  = 4'd9,
        CLS_EAPOL   = 4'd10,
        CLS_OTHER   = 4'd11
    } class_t;

    // per-packet parse state as it stands after the current byte
    typedef struct packed {
        logic [15:0] ethertype;
        logic [7:0]  l4_protocol;
        logic [15:0] payload_left;
        logic        chain_done;
        logic [31:0] port_bytes;
        logic [2:0]  captured_count;
    } flow_t;

    typedef struct packed {
        class_t      packet_class;
        logic [15:0] source_port;
        logic [15:0] dst_port;
        logic        ports_valid;
        logic [7:0]  icmp_type;
        logic [7:0]  icmp_code;
    } result_t;

    typedef struct packed {
        logic [31:0] port_bytes;
        logic [2:0]  captured_count;
    } capture_t;

    function automatic logic is_ext(input logic [7:0] t);
        return t == PROTO_HOPOPT || t == PROTO_ROUTE || t == PROTO_FRAG ||
               t == PROTO_DSTOPT || t == PROTO_AUTH;
    endfunction

    // extension header length in bytes, at most 2048
    function automatic logic [11:0] ext_len(input logic [7:0] t, input logic [7:0] len_byte);
        logic [11:0] lb;
        lb = {4'd0, len_byte};
        if (t == PROTO_FRAG)
            return 12'(OPT_UNIT);
        else if (t == PROTO_AUTH)
            return 12'((lb + 12'd2) * 12'(AUTH_UNIT));
        else
            return 12'((lb + 12'd1) * 12'(OPT_UNIT));
    endfunction

    // store a byte into the next free slot, first byte in bits 31..24
    function automatic capture_t capture(input capture_t c, input logic [7:0] b);
        capture_t r;
        r = c;
        if (c.captured_count < 3'(PORT_BYTES)) begin
            r.port_bytes = c.port_bytes | ({24'd0, b} << {~c.captured_count[1:0], 3'b000});
            r.captured_count = c.captured_count + 3'd1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/wpe_parse.sv =====
// Per-byte parse state: offset counter, IPv4 header length, IPv6 extension
// header walk and port byte capture. Uses wpe_pkg.
`default_nettype none

module wpe_parse #(
    parameter int OFFSET_WIDTH = 16
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         accept,
    input  wire logic [15:0]  ether_kind,
    input  wire logic [7:0]   data_byte,
    input  wire logic         first_byte,
    output wpe_pkg::flow_t    flow
);

    localparam logic [OFFSET_WIDTH-1:0] OFS_MAX = '1;

    logic [OFFSET_WIDTH-1:0] byte_offset_reg, byte_offset_next;
    logic [15:0]             ethertype_reg, ethertype_next;
    logic [5:0]              ihl_reg, ihl_next;
    logic [7:0]              proto_reg, proto_next;
    logic [OFFSET_WIDTH-1:0] hdr_ofs_reg, hdr_ofs_next;
    logic [15:0]             pl_reg, pl_next;
    logic                    cd_reg, cd_next;
    wpe_pkg::capture_t       cap_reg, cap_next;

    logic [OFFSET_WIDTH-1:0] o;
    logic [OFFSET_WIDTH-1:0] h;
    logic [OFFSET_WIDTH-1:0] ofs_diff;
    logic [OFFSET_WIDTH:0]   hdr_sum;
    logic [11:0]             hlen;
    logic                    ext;

    always_comb
    begin
        if (first_byte) begin
            ethertype_next = ether_kind;
            byte_offset_next = '0;
            ihl_next = '0;
            proto_next = '0;
            hdr_ofs_next = OFFSET_WIDTH'(wpe_pkg::V6_HDR_BYTES);
            pl_next = '0;
            cd_next = 1'b0;
            cap_next = '0;
        end else begin
            ethertype_next = ethertype_reg;
            byte_offset_next = byte_offset_reg;
            ihl_next = ihl_reg;
            proto_next = proto_reg;
            hdr_ofs_next = hdr_ofs_reg;
            pl_next = pl_reg;
            cd_next = cd_reg;
            cap_next = cap_reg;
        end
        o = byte_offset_next;
        h = hdr_ofs_next;
        ofs_diff = '0;
        hdr_sum = '0;
        hlen = '0;
        ext = 1'b0;

        if (o != OFS_MAX) begin
            byte_offset_next = o + OFFSET_WIDTH'(1);
            if (ethertype_next == wpe_pkg::ETH_IPV4) begin
                if (o == OFFSET_WIDTH'(0))
                    ihl_next = {data_byte[3:0], 2'b00};
                if (o == OFFSET_WIDTH'(9))
                    proto_next = data_byte;
                ofs_diff = o - OFFSET_WIDTH'(ihl_next);
                if (o >= OFFSET_WIDTH'(ihl_next) &&
                    ofs_diff < OFFSET_WIDTH'(wpe_pkg::PORT_BYTES))
                    cap_next = wpe_pkg::capture(cap_next, data_byte);
            end else if (ethertype_next == wpe_pkg::ETH_IPV6) begin
                if (o == OFFSET_WIDTH'(4))
                    pl_next = {data_byte, 8'd0};
                else if (o == OFFSET_WIDTH'(5))
                    pl_next = pl_next | {8'd0, data_byte};
                else if (o == OFFSET_WIDTH'(6))
                    proto_next = data_byte;
                ofs_diff = o - h;
                ext = wpe_pkg::is_ext(proto_next);
                if (o >= h && ofs_diff < OFFSET_WIDTH'(wpe_pkg::PORT_BYTES) &&
                    pl_next != 16'd0 && !(cd_next && ext)) begin
                    if (o == h && !ext)
                        cd_next = 1'b1;
                    cap_next = wpe_pkg::capture(cap_next, data_byte);
                    // second byte of an ext header: next header, or chain done
                    if (!cd_next && ofs_diff == OFFSET_WIDTH'(1)) begin
                        hlen = wpe_pkg::ext_len(proto_next, data_byte);
                        if (pl_next <= {4'd0, hlen}) begin
                            cd_next = 1'b1;
                        end else begin
                            hdr_sum = {1'b0, h} + (OFFSET_WIDTH+1)'(hlen);
                            proto_next = cap_next.port_bytes[31:24];
                            hdr_ofs_next = hdr_sum[OFFSET_WIDTH] ? OFS_MAX
                                                                 : hdr_sum[OFFSET_WIDTH-1:0];
                            pl_next = pl_next - {4'd0, hlen};
                        end
                        cap_next = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            byte_offset_reg <= '0;
            ethertype_reg <= '0;
            ihl_reg <= '0;
            proto_reg <= '0;
            hdr_ofs_reg <= '0;
            pl_reg <= '0;
            cd_reg <= 1'b0;
            cap_reg <= '0;
        end else if (accept) begin
            byte_offset_reg <= byte_offset_next;
            ethertype_reg <= ethertype_next;
            ihl_reg <= ihl_next;
            proto_reg <= proto_next;
            hdr_ofs_reg <= hdr_ofs_next;
            pl_reg <= pl_next;
            cd_reg <= cd_next;
            cap_reg <= cap_next;
        end
    end

    assign flow.ethertype = ethertype_next;
    assign flow.l4_protocol = proto_next;
    assign flow.payload_left = pl_next;
    assign flow.chain_done = cd_next;
    assign flow.port_bytes = cap_next.port_bytes;
    assign flow.captured_count = cap_next.captured_count;

endmodule

`default_nettype wire

// ===== hdl/wpe_classify.sv =====
// Packet classification and port / ICMP field selection from the parse
// state after the last byte. Uses wpe_pkg.
`default_nettype none

module wpe_classify (
    input  wire wpe_pkg::flow_t   flow,
    input  wire logic [15:0]      vendor_ethertype,
    output wpe_pkg::result_t      result
);

    wpe_pkg::class_t cls;
    logic            pv;
    logic [7:0]      icmp_t;
    logic [7:0]      icmp_c;

    always_comb
    begin
        pv = 1'b0;
        icmp_t = '0;
        icmp_c = '0;
        priority if (flow.ethertype == wpe_pkg::ETH_IPV4) begin
            unique case (flow.l4_protocol)
                wpe_pkg::PROTO_UDP:  cls = wpe_pkg::CLS_V4UDP;
                wpe_pkg::PROTO_TCP:  cls = wpe_pkg::CLS_V4TCP;
                wpe_pkg::PROTO_ICMP: cls = wpe_pkg::CLS_V4ICMP;
                wpe_pkg::PROTO_IGMP: cls = wpe_pkg::CLS_V4IGMP;
                default:             cls = wpe_pkg::CLS_V4OTHER;
            endcase
            if (cls == wpe_pkg::CLS_V4ICMP) begin
                if (flow.captured_count >= 3'd1)
                    icmp_t = flow.port_bytes[31:24];
                if (flow.captured_count >= 3'd2)
                    icmp_c = flow.port_bytes[23:16];
            end
            pv = (cls == wpe_pkg::CLS_V4UDP || cls == wpe_pkg::CLS_V4TCP) &&
                 flow.captured_count == 3'(wpe_pkg::PORT_BYTES);
        end else if (flow.ethertype == wpe_pkg::ETH_IPV6) begin
            if (flow.payload_left != 16'd0 && flow.l4_protocol == wpe_pkg::PROTO_TCP)
                cls = wpe_pkg::CLS_V6TCP;
            else if (flow.payload_left != 16'd0 && flow.l4_protocol == wpe_pkg::PROTO_UDP)
                cls = wpe_pkg::CLS_V6UDP;
            else
                cls = wpe_pkg::CLS_V6OTHER;
            pv = cls != wpe_pkg::CLS_V6OTHER && flow.chain_done &&
                 flow.captured_count == 3'(wpe_pkg::PORT_BYTES);
        end else if (flow.ethertype == wpe_pkg::ETH_ARP) begin
            cls = wpe_pkg::CLS_ARP;
        end else if (flow.ethertype == vendor_ethertype) begin
            cls = wpe_pkg::CLS_VENDOR;
        end else if (flow.ethertype == wpe_pkg::ETH_EAPOL) begin
            cls = wpe_pkg::CLS_EAPOL;
        end else begin
            cls = wpe_pkg::CLS_OTHER;
        end
    end

    assign result.packet_class = cls;
    assign result.source_port = pv ? flow.port_bytes[31:16] : 16'd0;
    assign result.dst_port = pv ? flow.port_bytes[15:0] : 16'd0;
    assign result.ports_valid = pv;
    assign result.icmp_type = icmp_t;
    assign result.icmp_code = icmp_c;

endmodule

`default_nettype wire

// ===== hdl/wpe_out_reg.sv =====
// Result register with valid/stall handshake; stalls the input side while a
// result is held by out_stall. Uses wpe_pkg.
`default_nettype none

module wpe_out_reg (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire wpe_pkg::result_t  result_in,
    input  wire logic              out_stall,
    output logic                   out_valid,
    output logic                   busy,
    output wpe_pkg::result_t       result_out
);

    logic             valid_reg, valid_next;
    wpe_pkg::result_t result_reg;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (out_stall)
            valid_next = valid_reg;
        else
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            result_reg <= result_in;
    end

    assign out_valid = valid_reg;
    assign busy = valid_reg && out_stall;
    assign result_out = result_reg;

endmodule

`default_nettype wire

// ===== hdl/wake_packet_port_extractor.sv =====
// Wake packet port extractor: one byte per cycle in, one result per packet.
// Latency: the result is valid the cycle after its last byte is accepted.
// Throughput: one byte every cycle; a byte is refused only while a result
// is held by out_stall. Reset clears the parse state, drops any pending
// result and sets the vendor ethertype register to 0x886C.
// Depends on wpe_pkg, wpe_parse, wpe_classify, wpe_out_reg.
`default_nettype none

module wake_packet_port_extractor #(
    parameter int OFFSET_WIDTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [15:0] ether_kind,
    input  wire logic [7:0]  data_byte,
    input  wire logic        first_byte,
    input  wire logic        last_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [3:0]       packet_class,
    output logic [15:0]      source_port,
    output logic [15:0]      dst_port,
    output logic             ports_valid,
    output logic [7:0]       icmp_type_out,
    output logic [7:0]       icmp_code_out
);

    logic [15:0]       vendor_eth_reg;
    logic              accept;
    logic              busy;
    wpe_pkg::flow_t    flow;
    wpe_pkg::result_t  result_comb;
    wpe_pkg::result_t  result_q;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vendor_eth_reg <= wpe_pkg::VENDOR_ETH_RESET;
        else if (psel && penable && pwrite && paddr == wpe_pkg::REG_VENDOR_ETH)
            vendor_eth_reg <= pwdata[15:0];
    end

    assign prdata = (paddr == wpe_pkg::REG_VENDOR_ETH) ? {16'd0, vendor_eth_reg} : 32'd0;

    assign in_stall = busy;
    assign accept = in_valid && !busy;

    wpe_parse #(
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .ether_kind (ether_kind),
        .data_byte  (data_byte),
        .first_byte (first_byte),
        .flow       (flow)
    );

    wpe_classify u_classify (
        .flow             (flow),
        .vendor_ethertype (vendor_eth_reg),
        .result           (result_comb)
    );

    wpe_out_reg u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept && last_byte),
        .result_in  (result_comb),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .busy       (busy),
        .result_out (result_q)
    );

    assign packet_class = result_q.packet_class;
    assign source_port = result_q.source_port;
    assign dst_port = result_q.dst_port;
    assign ports_valid = result_q.ports_valid;
    assign icmp_type_out = result_q.icmp_type;
    assign icmp_code_out = result_q.icmp_code;

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last_byte |=> out_valid)
        else $error("accepted last byte produced no result");

    a_ports_only_tcp_udp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ports_valid |->
            packet_class == wpe_pkg::CLS_V4UDP || packet_class == wpe_pkg::CLS_V4TCP ||
            packet_class == wpe_pkg::CLS_V6TCP || packet_class == wpe_pkg::CLS_V6UDP)
        else $error("ports reported for a non TCP/UDP class");

    a_icmp_only_v4icmp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (icmp_type_out != 8'd0 || icmp_code_out != 8'd0) |->
            packet_class == wpe_pkg::CLS_V4ICMP)
        else $error("ICMP fields set outside the IPv4 ICMP class");

    a_ports_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !ports_valid |-> source_port == 16'd0 && dst_port == 16'd0)
        else $error("ports nonzero without ports_valid");

endmodule

`default_nettype wire

// ===== verif/wpe_port_checker.sv =====
// Port checker for the wake packet port extractor: follows the byte and
// result channels and the APB port, predicts each packet's result and compares.
// Depends on wpe_pkg.
`default_nettype none

module wpe_port_checker #(
    parameter int OFFSET_WIDTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic [31:0] prdata,
    input  wire logic        pready,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic [15:0] ether_kind,
    input  wire logic [7:0]  data_byte,
    input  wire logic        first_byte,
    input  wire logic        last_byte,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [3:0]  packet_class,
    input  wire logic [15:0] source_port,
    input  wire logic [15:0] dst_port,
    input  wire logic        ports_valid,
    input  wire logic [7:0]  icmp_type_out,
    input  wire logic [7:0]  icmp_code_out,
    output int               mismatches,
    output int               waiting
);

    localparam int OFS_MAX = (1 << OFFSET_WIDTH) - 1;

    logic [15:0]      vendor_eth;
    logic [15:0]      byte_pos;
    logic [15:0]      pkt_eth;
    logic [15:0]      hdr_start;
    logic [15:0]      v6_left;
    logic [5:0]       v4_hdr_len;
    logic [7:0]       proto;
    logic             walk_done;
    logic [31:0]      port_word;
    logic [2:0]       port_cnt;
    wpe_pkg::result_t due_results[$];
    int               bad;

    task automatic clear_flow();
        byte_pos   = '0;
        v4_hdr_len = '0;
        proto      = '0;
        hdr_start  = '0;
        v6_left    = '0;
        walk_done  = 1'b0;
        port_word  = '0;
        port_cnt   = '0;
    endtask

    task automatic take_port_byte(input logic [7:0] b);
        if (port_cnt < 3'd4) begin
            port_word = port_word | (32'(b) << (8 * (3 - int'(port_cnt))));
            port_cnt  = port_cnt + 3'd1;
        end
    endtask

    task automatic v4_byte(input int o, input logic [7:0] b);
        if (o == 0)
            v4_hdr_len = {b[3:0], 2'b00};
        if (o == 9)
            proto = b;
        if (o >= int'(v4_hdr_len) && o - int'(v4_hdr_len) < 4)
            take_port_byte(b);
    endtask

    task automatic v6_byte(input int o, input logic [7:0] b);
        int   h;
        int   len;
        int   nh;
        logic ext;
        h = int'(hdr_start);
        if (o == 4)
            v6_left = {b, 8'h00};
        else if (o == 5)
            v6_left = v6_left | {8'h00, b};
        else if (o == 6)
            proto = b;
        if (o < h || o - h >= 4 || v6_left == 16'd0)
            return;
        ext = proto == wpe_pkg::PROTO_HOPOPT || proto == wpe_pkg::PROTO_ROUTE ||
              proto == wpe_pkg::PROTO_FRAG || proto == wpe_pkg::PROTO_DSTOPT ||
              proto == wpe_pkg::PROTO_AUTH;
        if (walk_done && ext)
            return;
        if (o == h && !ext)
            walk_done = 1'b1;
        take_port_byte(b);
        // second byte of an extension header: its length is known, hop on or end walk
        if (!walk_done && o == h + 1) begin
            if (proto == wpe_pkg::PROTO_FRAG)
                len = wpe_pkg::OPT_UNIT;
            else if (proto == wpe_pkg::PROTO_AUTH)
                len = (int'(b) + 2) * wpe_pkg::AUTH_UNIT;
            else
                len = (int'(b) + 1) * wpe_pkg::OPT_UNIT;
            if (int'(v6_left) <= len) begin
                walk_done = 1'b1;
            end
            else begin
                nh        = h + len;
                proto     = port_word[31:24];
                hdr_start = (nh > OFS_MAX) ? 16'(OFS_MAX) : 16'(nh);
                v6_left   = v6_left - 16'(len);
            end
            port_word = '0;
            port_cnt  = '0;
        end
    endtask

    function automatic wpe_pkg::result_t classify();
        wpe_pkg::result_t r;
        r = '0;
        if (pkt_eth == wpe_pkg::ETH_IPV4) begin
            case (proto)
                wpe_pkg::PROTO_UDP:  r.packet_class = wpe_pkg::CLS_V4UDP;
                wpe_pkg::PROTO_TCP:  r.packet_class = wpe_pkg::CLS_V4TCP;
                wpe_pkg::PROTO_ICMP: r.packet_class = wpe_pkg::CLS_V4ICMP;
                wpe_pkg::PROTO_IGMP: r.packet_class = wpe_pkg::CLS_V4IGMP;
                default:             r.packet_class = wpe_pkg::CLS_V4OTHER;
            endcase
            if (r.packet_class == wpe_pkg::CLS_V4ICMP) begin
                if (port_cnt >= 3'd1)
                    r.icmp_type = port_word[31:24];
                if (port_cnt >= 3'd2)
                    r.icmp_code = port_word[23:16];
            end
            r.ports_valid = (proto == wpe_pkg::PROTO_UDP || proto == wpe_pkg::PROTO_TCP) &&
                            port_cnt == 3'd4;
        end
        else if (pkt_eth == wpe_pkg::ETH_IPV6) begin
            if (v6_left != 16'd0 && proto == wpe_pkg::PROTO_TCP)
                r.packet_class = wpe_pkg::CLS_V6TCP;
            else if (v6_left != 16'd0 && proto == wpe_pkg::PROTO_UDP)
                r.packet_class = wpe_pkg::CLS_V6UDP;
            else
                r.packet_class = wpe_pkg::CLS_V6OTHER;
            r.ports_valid = r.packet_class != wpe_pkg::CLS_V6OTHER && walk_done &&
                            port_cnt == 3'd4;
        end
        else if (pkt_eth == wpe_pkg::ETH_ARP)
            r.packet_class = wpe_pkg::CLS_ARP;
        else if (pkt_eth == vendor_eth)
            r.packet_class = wpe_pkg::CLS_VENDOR;
        else if (pkt_eth == wpe_pkg::ETH_EAPOL)
            r.packet_class = wpe_pkg::CLS_EAPOL;
        else
            r.packet_class = wpe_pkg::CLS_OTHER;
        if (r.ports_valid) begin
            r.source_port = port_word[31:16];
            r.dst_port    = port_word[15:0];
        end
        return r;
    endfunction

    task automatic parse_byte();
        int o;
        if (first_byte) begin
            clear_flow();
            pkt_eth   = ether_kind;
            hdr_start = 16'(wpe_pkg::V6_HDR_BYTES);
        end
        o = int'(byte_pos);
        // the offset counter sticks at its top value, bytes there are dropped
        if (o < OFS_MAX) begin
            if (pkt_eth == wpe_pkg::ETH_IPV4)
                v4_byte(o, data_byte);
            else if (pkt_eth == wpe_pkg::ETH_IPV6)
                v6_byte(o, data_byte);
            byte_pos = 16'(o + 1);
        end
        if (last_byte)
            due_results.push_back(classify());
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            bad++;
        end
    endtask

    task automatic check_result();
        wpe_pkg::result_t want;
        if (due_results.size() == 0) begin
            $error("result with nothing outstanding, packet_class %0h", packet_class);
            bad++;
            return;
        end
        want = due_results.pop_front();
        check_field("packet_class", 16'(want.packet_class), 16'(packet_class));
        check_field("source_port", want.source_port, source_port);
        check_field("dst_port", want.dst_port, dst_port);
        check_field("ports_valid", 16'(want.ports_valid), 16'(ports_valid));
        check_field("icmp_type_out", 16'(want.icmp_type), 16'(icmp_type_out));
        check_field("icmp_code_out", 16'(want.icmp_code), 16'(icmp_code_out));
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vendor_eth = wpe_pkg::VENDOR_ETH_RESET;
            pkt_eth    = '0;
            clear_flow();
            due_results.delete();
            bad        = 0;
            mismatches <= 0;
            waiting    <= 0;
        end
        else begin
            if (out_valid && !out_stall)
                check_result();
            if (psel && penable && !pwrite && pready && paddr == wpe_pkg::REG_VENDOR_ETH) begin
                check_field("prdata", vendor_eth, prdata[15:0]);
                check_field("prdata_high", 16'd0, prdata[31:16]);
            end
            if (psel && penable && pwrite && pready && paddr == wpe_pkg::REG_VENDOR_ETH)
                vendor_eth = pwdata[15:0];
            if (in_valid && !in_stall)
                parse_byte();
            mismatches <= bad;
            waiting    <= due_results.size();
        end
    end

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Top of the wake packet port extractor testbench: clock, reset, packet and
// register stimulus, receiver stalls and the verdict.
// Depends on wpe_pkg, wake_packet_port_extractor and wpe_port_checker.
`default_nettype none

module tb;

    localparam logic [7:0] PROTO_ICMP6 = 8'd58;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = wpe_pkg::REG_VENDOR_ETH;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [15:0] ether_kind = '0;
    logic [7:0]  data_byte = '0;
    logic        first_byte = 1'b0;
    logic        last_byte = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [3:0]  packet_class;
    logic [15:0] source_port;
    logic [15:0] dst_port;
    logic        ports_valid;
    logic [7:0]  icmp_type_out;
    logic [7:0]  icmp_code_out;
    int          mismatches;
    int          waiting;

    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int          hold_reqs = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    int          sent_bytes = 0;
    logic [15:0] vendor_now = wpe_pkg::VENDOR_ETH_RESET;
    logic [7:0]  pkt[$];

    wake_packet_port_extractor u_dut (.*);

    wpe_port_checker #(.OFFSET_WIDTH(16)) u_checker (.*);

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // receiver: random stalls, or a long hold-off when one is requested
    always @(posedge clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (hold_reqs != hold_seen) begin
            hold_seen = hold_reqs;
            hold_left = 300;
            out_stall <= 1'b1;
        end
        else begin
            out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    initial begin
        #2000000;
        $display("wake_packet_port_extractor: mismatch");
        $finish;
    end

    task automatic send_byte(input logic [15:0] eth, input logic [7:0] d,
                             input logic f, input logic l);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        ether_kind <= eth;
        data_byte  <= d;
        first_byte <= f;
        last_byte  <= l;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        sent_bytes++;
    endtask

    task automatic send_pkt(input logic [15:0] eth);
        int i;
        for (i = 0; i < pkt.size(); i++)
            send_byte((i == 0) ? eth : 16'($urandom), pkt[i], i == 0, i == pkt.size() - 1);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (waiting != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic apb_write(input logic [15:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= wpe_pkg::REG_VENDOR_ETH;
        pwdata  <= {16'($urandom), v};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        // read the register back
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        vendor_now = v;
    endtask

    function automatic void add_rand(input int n);
        repeat (n) pkt.push_back(8'($urandom));
    endfunction

    function automatic void trim_to(input int n);
        while (pkt.size() > n)
            void'(pkt.pop_back());
    endfunction

    function automatic void put32(input int at, input logic [31:0] v);
        pkt[at]     = v[31:24];
        pkt[at + 1] = v[23:16];
        pkt[at + 2] = v[15:8];
        pkt[at + 3] = v[7:0];
    endfunction

    // IPv4 header of IHL words (at least up to the protocol byte), then l4 bytes
    function automatic void start_v4(input logic [3:0] ihl, input logic [7:0] proto,
                                     input int l4);
        int hdr;
        hdr = int'(ihl) * 4;
        if (hdr < 10)
            hdr = 10;
        pkt.delete();
        add_rand(hdr + l4);
        pkt[0] = {4'($urandom), ihl};
        pkt[9] = proto;
    endfunction

    function automatic void start_v6(input logic [7:0] nh);
        pkt.delete();
        add_rand(40);
        pkt[6] = nh;
    endfunction

    function automatic void set_plen(input int v);
        pkt[4] = 8'(v >> 8);
        pkt[5] = 8'(v);
    endfunction

    function automatic void add_ext(input logic [7:0] kind, input logic [7:0] nxt,
                                    input logic [7:0] lb);
        int n;
        if (kind == wpe_pkg::PROTO_FRAG)
            n = wpe_pkg::OPT_UNIT;
        else if (kind == wpe_pkg::PROTO_AUTH)
            n = (int'(lb) + 2) * wpe_pkg::AUTH_UNIT;
        else
            n = (int'(lb) + 1) * wpe_pkg::OPT_UNIT;
        pkt.push_back(nxt);
        pkt.push_back(lb);
        add_rand(n - 2);
    endfunction

    function automatic logic [7:0] pick_ext();
        case ($urandom_range(4))
            0:       return wpe_pkg::PROTO_HOPOPT;
            1:       return wpe_pkg::PROTO_ROUTE;
            2:       return wpe_pkg::PROTO_FRAG;
            3:       return wpe_pkg::PROTO_AUTH;
            default: return wpe_pkg::PROTO_DSTOPT;
        endcase
    endfunction

    function automatic logic [7:0] pick_v6_l4();
        case ($urandom_range(5))
            0, 1:    return wpe_pkg::PROTO_TCP;
            2, 3:    return wpe_pkg::PROTO_UDP;
            4:       return PROTO_ICMP6;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic rand_packet();
        int          k;
        int          depth;
        logic [3:0]  ihl;
        logic [7:0]  proto;
        logic [7:0]  cur;
        logic [7:0]  nxt;
        logic [7:0]  lb;
        logic [15:0] eth;
        k = $urandom_range(99);
        if (k < 35) begin
            ihl = ($urandom_range(3) == 0) ? 4'($urandom) : 4'd5;
            case ($urandom_range(4))
                0:       proto = wpe_pkg::PROTO_UDP;
                1:       proto = wpe_pkg::PROTO_TCP;
                2:       proto = wpe_pkg::PROTO_ICMP;
                3:       proto = wpe_pkg::PROTO_IGMP;
                default: proto = 8'($urandom);
            endcase
            start_v4(ihl, proto, $urandom_range(3, 8));
            if ($urandom_range(9) == 0)
                trim_to($urandom_range(1, pkt.size()));
            send_pkt(wpe_pkg::ETH_IPV4);
        end
        else if (k < 70) begin
            depth = $urandom_range(3);
            cur = (depth > 0) ? pick_ext() : pick_v6_l4();
            start_v6(cur);
            while (depth > 0) begin
                depth--;
                nxt = (depth > 0) ? pick_ext() : pick_v6_l4();
                if ($urandom_range(39) == 0)
                    lb = 8'($urandom);
                else if ($urandom_range(15) == 0)
                    lb = 8'($urandom_range(31));
                else
                    lb = 8'($urandom_range(2));
                add_ext(cur, nxt, lb);
                cur = nxt;
            end
            add_rand($urandom_range(4, 10));
            case ($urandom_range(9))
                0:       set_plen(0);
                1:       set_plen($urandom_range(65535));
                2:       set_plen($urandom_range(1, 24));
                default: set_plen(pkt.size() - 40);
            endcase
            if ($urandom_range(9) == 0)
                trim_to($urandom_range(1, pkt.size()));
            // long extension headers are cut short to keep the byte count down
            trim_to(128);
            send_pkt(wpe_pkg::ETH_IPV6);
        end
        else if (k < 85) begin
            case ($urandom_range(3))
                0:       eth = wpe_pkg::ETH_ARP;
                1:       eth = wpe_pkg::ETH_EAPOL;
                2:       eth = vendor_now;
                default: eth = 16'($urandom);
            endcase
            pkt.delete();
            add_rand($urandom_range(1, 8));
            send_pkt(eth);
        end
        else begin
            // loose bytes: stray first and last marks, mid-packet continuations
            repeat ($urandom_range(1, 6))
                send_byte(16'($urandom), 8'($urandom), $urandom_range(1) == 1,
                          $urandom_range(9) < 3);
        end
    endtask

    task automatic run_random(input int min_bytes, input int min_pkts);
        int start_b;
        int n;
        start_b = sent_bytes;
        n = 0;
        while (sent_bytes - start_b < min_bytes || n < min_pkts) begin
            rand_packet();
            n++;
            if (n == min_pkts / 2)
                drain();
        end
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // bytes with no first mark after reset belong to an ethertype-zero packet
        send_byte(16'hFFFF, 8'h00, 1'b0, 1'b0);
        send_byte(wpe_pkg::ETH_IPV4, 8'hFF, 1'b0, 1'b1);
        // one-byte packet, then IPv4 ending before the protocol byte
        start_v4(4'd5, wpe_pkg::PROTO_UDP, 4);
        trim_to(1);
        send_pkt(wpe_pkg::ETH_IPV4);
        start_v4(4'd5, wpe_pkg::PROTO_UDP, 4);
        trim_to(9);
        send_pkt(wpe_pkg::ETH_IPV4);
        start_v4(4'd5, wpe_pkg::PROTO_UDP, 4);
        put32(20, 32'hFFFF_FFFF);
        send_pkt(wpe_pkg::ETH_IPV4);
        start_v4(4'd15, wpe_pkg::PROTO_TCP, 6);
        put32(60, 32'h0000_0000);
        send_pkt(wpe_pkg::ETH_IPV4);
        start_v4(4'd5, wpe_pkg::PROTO_ICMP, 8);
        send_pkt(wpe_pkg::ETH_IPV4);
        start_v4(4'd5, wpe_pkg::PROTO_ICMP, 1);
        send_pkt(wpe_pkg::ETH_IPV4);
        start_v4(4'd5, wpe_pkg::PROTO_IGMP, 8);
        send_pkt(wpe_pkg::ETH_IPV4);
        start_v4(4'd5, 8'hFF, 8);
        send_pkt(wpe_pkg::ETH_IPV4);
        // IHL below five: ports overlap the IP header
        start_v4(4'd0, wpe_pkg::PROTO_UDP, 0);
        send_pkt(wpe_pkg::ETH_IPV4);
        start_v4(4'd1, wpe_pkg::PROTO_TCP, 2);
        send_pkt(wpe_pkg::ETH_IPV4);
        start_v6(wpe_pkg::PROTO_TCP);
        add_rand(20);
        set_plen(pkt.size() - 40);
        send_pkt(wpe_pkg::ETH_IPV6);
        // every extension header kind in one chain
        start_v6(wpe_pkg::PROTO_HOPOPT);
        add_ext(wpe_pkg::PROTO_HOPOPT, wpe_pkg::PROTO_ROUTE, 8'd0);
        add_ext(wpe_pkg::PROTO_ROUTE, wpe_pkg::PROTO_FRAG, 8'd1);
        add_ext(wpe_pkg::PROTO_FRAG, wpe_pkg::PROTO_AUTH, 8'hFF);
        add_ext(wpe_pkg::PROTO_AUTH, wpe_pkg::PROTO_DSTOPT, 8'd1);
        add_ext(wpe_pkg::PROTO_DSTOPT, wpe_pkg::PROTO_UDP, 8'd0);
        add_rand(8);
        set_plen(pkt.size() - 40);
        send_pkt(wpe_pkg::ETH_IPV6);
        start_v6(wpe_pkg::PROTO_UDP);
        add_rand(8);
        set_plen(0);
        send_pkt(wpe_pkg::ETH_IPV6);
        // extension header as long as what is left of the payload
        start_v6(wpe_pkg::PROTO_HOPOPT);
        add_ext(wpe_pkg::PROTO_HOPOPT, wpe_pkg::PROTO_UDP, 8'd3);
        add_rand(8);
        set_plen(32);
        send_pkt(wpe_pkg::ETH_IPV6);
        start_v6(wpe_pkg::PROTO_TCP);
        add_rand(8);
        set_plen(pkt.size() - 40);
        trim_to(42);
        send_pkt(wpe_pkg::ETH_IPV6);
        start_v6(PROTO_ICMP6);
        add_rand(8);
        set_plen(pkt.size() - 40);
        send_pkt(wpe_pkg::ETH_IPV6);
        pkt.delete();
        add_rand(4);
        send_pkt(wpe_pkg::ETH_ARP);
        send_pkt(wpe_pkg::ETH_EAPOL);
        send_pkt(wpe_pkg::VENDOR_ETH_RESET);
        send_pkt(16'hFFFF);
        send_pkt(16'h0000);

        drain();
        apb_write(16'h0000);
        tx_idle_pct = 8;
        rx_idle_pct <= 69;
        run_random(40, 2);

        drain();
        apb_write(16'hFFFF);
        tx_idle_pct = 69;
        rx_idle_pct <= 8;
        run_random(40, 2);

        // vendor value clashing with IPv4; long receiver hold while short items pile up
        drain();
        apb_write(wpe_pkg::ETH_IPV4);
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        hold_reqs <= hold_reqs + 1;
        repeat (16) begin
            pkt.delete();
            add_rand($urandom_range(1, 2));
            send_pkt(wpe_pkg::ETH_EAPOL);
        end
        run_random(40, 2);

        // vendor value from the full range
        drain();
        apb_write(16'($urandom));
        pkt.delete();
        add_rand(4);
        send_pkt(vendor_now);

        drain();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("wake_packet_port_extractor: match");
        else
            $display("wake_packet_port_extractor: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
